>>> design/sparse_row_relaxation_smoother_core_macros.svh
// assertion helpers for the smoother core
`ifndef SPARSE_ROW_RELAXATION_SMOOTHER_CORE_MACROS_SVH
`define SPARSE_ROW_RELAXATION_SMOOTHER_CORE_MACROS_SVH

// same-cycle implication, held off while reset is asserted
`define SRRS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("srrs assertion failed");

// next-cycle implication, held off while reset is asserted
`define SRRS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("srrs assertion failed");

`endif

>>> design/srrs_pkg.sv
package srrs_pkg;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_NZ    = 2'd1,
        OP_READ  = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_ZERO_DIAG = 2'd1,
        ST_SAT       = 2'd2
    } t_status;

    localparam logic CFG_MODE    = 1'b0;
    localparam logic CFG_DAMPING = 1'b1;

    localparam logic        MODE_RESET    = 1'b1;
    localparam logic [16:0] DAMPING_RESET = 17'd52429;   // 0.8 in q16.16

    typedef struct packed {
        logic [1:0]         op;
        logic [11:0]        index;
        logic [11:0]        row;
        logic signed [31:0] value;
        logic signed [31:0] rhs;
        logic               last;
    } t_in_item;

    typedef struct packed {
        logic [11:0]        out_row;
        logic signed [31:0] new_value;
        t_status            status;
    } t_out_item;

endpackage

>>> design/srrs_ifs.sv
interface srrs_in_if;
    import srrs_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface srrs_out_if;
    import srrs_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface srrs_cfg_if;
    logic        valid;
    logic        ready;
    logic        index;
    logic [16:0] wdata;
    modport source (output valid, output index, output wdata, input ready);
    modport sink   (input valid, input index, input wdata, output ready);
endinterface

>>> design/srrs_div.sv
module srrs_div import srrs_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [127:0] i_num,
    input  logic [63:0]  i_den,
    output logic         o_done,
    output logic [127:0] o_quot
);

    logic         r_busy;
    logic         r_done;
    logic [6:0]   r_cnt;
    logic [127:0] r_num;
    logic [63:0]  r_rem;
    logic [63:0]  r_den;

    logic [64:0]  w_sh;
    logic         w_take;

    // restoring step: shift in one numerator bit, subtract when it fits
    always_comb begin
        w_sh   = {r_rem, r_num[127]};
        w_take = (w_sh >= {1'b0, r_den});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_num  <= i_num;
                r_rem  <= '0;
                r_den  <= i_den;
            end else if (r_busy) begin
                r_rem  <= w_take ? 64'(w_sh - {1'b0, r_den}) : w_sh[63:0];
                r_num  <= {r_num[126:0], w_take};
                r_cnt  <= r_cnt + 7'd1;
                if (r_cnt == 7'd127) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_num;

endmodule

>>> design/sparse_row_relaxation_smoother_core.sv
// Gauss-Seidel style row smoother over a q16.16 solution vector held in an internal
// memory of VEC_DEPTH words. Transfers on the input channel either write a vector
// entry (op 0, no result), read one back (op 2, one result) or carry one CRS
// nonzero (op 1). One shared 32x32 multiplier forms value^2 and value*x[column]
// while a memory read fetches x[column]. On the nonzero flagged last the row end
// runs: two passes of the shared multiplier (diag*x and residual*weight) and a
// radix-2 divider, after which x[row] is rewritten and reported. Mode 0 applies
// damping*r/diag, mode 1 the spai-0 weight diag*r/sum(a^2). A zero diagonal (or zero
// square sum in mode 1) leaves x untouched with status 1; saturation gives status 2.
// The input is not ready while an item is in progress; one finished result may wait
// in the output register while the next item runs. Entries must be written before
// they are read; there is no clearing pass. Configuration is always ready.
`include "sparse_row_relaxation_smoother_core_macros.svh"

module sparse_row_relaxation_smoother_core import srrs_pkg::*; #(
    parameter int VEC_DEPTH = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    srrs_in_if.sink     i_in,
    srrs_out_if.source  o_out,
    srrs_cfg_if.sink    i_cfg
);

    localparam int AW = $clog2(VEC_DEPTH);

    typedef enum logic [3:0] {
        S_IDLE, S_DEC, S_RDX, S_NZ, S_OFF, S_XRD, S_XW, S_MUL,
        S_T, S_T2, S_DIV, S_DIVW, S_FIN, S_PUB
    } t_state;

    t_state r_state;

    // configuration
    logic        r_mode;
    logic [16:0] r_damping;

    // latched transfer and row accumulators
    t_in_item           r_in;
    logic signed [47:0] r_diag;
    logic signed [63:0] r_off;
    logic [63:0]        r_sq;
    logic               r_sat;

    // shared multiplier and row-end datapath
    logic [63:0]        r_prod;
    logic [1:0]         r_sh;
    logic [2:0]         r_k;
    logic               r_phase;      // 0 diag*x pass, 1 residual*weight pass
    logic [95:0]        r_ma;
    logic [63:0]        r_mb;
    logic [127:0]       r_acc;
    logic signed [81:0] r_t;
    logic               r_negc;
    logic signed [31:0] r_x;

    t_out_item r_res;
    t_out_item r_odata;
    logic      r_ovalid;

    // solution memory
    logic [31:0] mem [VEC_DEPTH];
    logic [31:0] r_rdata;
    logic [AW-1:0] w_raddr;
    logic [AW-1:0] w_waddr;
    logic          w_we;
    logic [31:0]   w_wdata;

    logic        w_idx_ok;
    logic        w_row_ok;
    logic [31:0] w_vmag;
    logic [31:0] w_xcol;
    logic [31:0] w_xcol_mag;
    logic [47:0] w_diag_mag;
    logic [31:0] w_x_mag;
    logic [1:0]  w_ai;
    logic        w_bj;
    logic [31:0] w_mul_a;
    logic [31:0] w_mul_b;
    logic [63:0] w_prod;
    logic        w_is_diag;
    logic        w_zero;
    logic        w_div_start;
    logic        w_div_done;
    logic [127:0] w_quot;
    logic [63:0]  w_den;
    logic [81:0]  w_tmag;

    logic [48:0] w_dsum;
    logic [64:0] w_osum;
    logic [64:0] w_ssum;
    logic [32:0] w_qm;
    logic [33:0] w_res;
    logic        w_fin_sat;
    logic [31:0] w_fin_val;

    srrs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (r_acc),
        .i_den   (w_den),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    always_comb begin
        w_idx_ok   = (32'(r_in.index) < 32'(VEC_DEPTH));
        w_row_ok   = (32'(r_in.row) < 32'(VEC_DEPTH));
        w_is_diag  = (r_in.index == r_in.row);
        w_vmag     = r_in.value[31] ? 32'(-r_in.value) : r_in.value;
        w_xcol     = w_idx_ok ? r_rdata : 32'd0;
        w_xcol_mag = w_xcol[31] ? 32'(-w_xcol) : w_xcol;
        w_diag_mag = r_diag[47] ? 48'(-r_diag) : r_diag;
        // magnitude of x[row] as it comes out of the memory
        w_x_mag    = (w_row_ok && r_rdata[31]) ? 32'(-r_rdata)
                                               : (w_row_ok ? r_rdata : 32'd0);
        w_zero     = (r_diag == 48'sd0) || (r_mode && (r_sq == 64'd0));
        w_tmag     = r_t[81] ? 82'(-r_t) : r_t;
        w_den      = r_mode ? r_sq : {w_diag_mag, 16'd0};

        // limb pair for the current partial product
        w_ai = r_k[2:1];
        w_bj = r_k[0];

        // shared multiplier operand select
        case (r_state)
            S_DEC: begin
                w_mul_a = w_vmag;
                w_mul_b = w_vmag;
            end
            S_NZ: begin
                w_mul_a = w_vmag;
                w_mul_b = w_xcol_mag;
            end
            default: begin
                w_mul_a = r_ma[{w_ai, 5'd0} +: 32];
                w_mul_b = r_mb[{w_bj, 5'd0} +: 32];
            end
        endcase
        w_prod = 64'(w_mul_a) * 64'(w_mul_b);

        // saturating accumulator sums
        w_dsum = {r_diag[47], r_diag} + {{17{r_in.value[31]}}, r_in.value};
        w_osum = (r_in.value[31] ^ w_xcol[31])
               ? {r_off[63], r_off} - {1'b0, r_prod}
               : {r_off[63], r_off} + {1'b0, r_prod};
        w_ssum = {1'b0, r_sq} + {1'b0, r_prod};

        // final correction, saturated to 2^32 before the add
        w_qm  = (w_quot[127:32] != 96'd0) ? 33'h1_0000_0000 : {1'b0, w_quot[31:0]};
        w_res = r_negc ? {{2{r_x[31]}}, r_x} - {1'b0, w_qm}
                       : {{2{r_x[31]}}, r_x} + {1'b0, w_qm};

        // new entry clamped to the 32-bit signed range
        w_fin_sat = (w_res[33] != w_res[31]) || (w_res[32] != w_res[31]);
        w_fin_val = w_fin_sat ? (w_res[33] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}})
                              : w_res[31:0];

        w_div_start = (r_state == S_DIV);

        // memory port
        w_raddr = (r_state == S_XRD) ? AW'(r_in.row) : AW'(r_in.index);
        w_we    = 1'b0;
        w_waddr = AW'(r_in.index);
        w_wdata = r_in.value;
        if (r_state == S_DEC && r_in.op == OP_WRITE && w_idx_ok) begin
            w_we = 1'b1;
        end else if (r_state == S_FIN && w_row_ok) begin
            w_we    = 1'b1;
            w_waddr = AW'(r_in.row);
            w_wdata = w_fin_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_waddr] <= w_wdata;
        end
        r_rdata <= mem[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_mode    <= MODE_RESET;
            r_damping <= DAMPING_RESET;
            r_diag    <= '0;
            r_off     <= '0;
            r_sq      <= '0;
            r_sat     <= 1'b0;
            r_ovalid  <= 1'b0;
            r_k       <= '0;
            r_phase   <= 1'b0;
        end else begin
            // configuration transfers
            if (i_cfg.valid) begin
                unique case (i_cfg.index)
                    CFG_MODE:    r_mode    <= i_cfg.wdata[0];
                    CFG_DAMPING: r_damping <= i_cfg.wdata;
                    default: ;
                endcase
            end

            // the publish state reloads the output register itself
            if (o_out.ready && r_state != S_PUB) begin
                r_ovalid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_in    <= i_in.data;
                        r_state <= S_DEC;
                    end
                end
                S_DEC: begin
                    // memory read of x[index] and value^2 both start here
                    r_prod <= w_prod;
                    case (r_in.op)
                        OP_READ: r_state <= S_RDX;
                        OP_NZ:   r_state <= S_NZ;
                        default: r_state <= S_IDLE;
                    endcase
                end
                S_RDX: begin
                    r_res.out_row   <= r_in.index;
                    r_res.new_value <= w_xcol;
                    r_res.status    <= ST_OK;
                    r_state         <= S_PUB;
                end
                S_NZ: begin
                    if (w_ssum[64]) begin
                        r_sq  <= '1;
                        r_sat <= 1'b1;
                    end else begin
                        r_sq <= w_ssum[63:0];
                    end
                    r_prod <= w_prod;
                    if (w_is_diag) begin
                        if (w_dsum[48] != w_dsum[47]) begin
                            r_diag <= w_dsum[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
                            r_sat  <= 1'b1;
                        end else begin
                            r_diag <= w_dsum[47:0];
                        end
                        r_state <= r_in.last ? S_XRD : S_IDLE;
                    end else begin
                        r_state <= S_OFF;
                    end
                end
                S_OFF: begin
                    if (w_osum[64] != w_osum[63]) begin
                        r_off <= w_osum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
                        r_sat <= 1'b1;
                    end else begin
                        r_off <= w_osum[63:0];
                    end
                    r_state <= r_in.last ? S_XRD : S_IDLE;
                end
                S_XRD: begin
                    // fetch x[row], start residual as rhs<<16 - offdiag
                    r_t <= {{34{r_in.rhs[31]}}, r_in.rhs, 16'd0}
                         - {{18{r_off[63]}}, r_off};
                    r_state <= S_XW;
                end
                S_XW: begin
                    r_x <= w_row_ok ? r_rdata : 32'd0;
                    if (w_zero) begin
                        r_res.out_row   <= r_in.row;
                        r_res.new_value <= w_row_ok ? r_rdata : 32'd0;
                        r_res.status    <= ST_ZERO_DIAG;
                        r_diag  <= '0;
                        r_off   <= '0;
                        r_sq    <= '0;
                        r_sat   <= 1'b0;
                        r_state <= S_PUB;
                    end else begin
                        r_ma    <= {48'd0, w_diag_mag};
                        r_mb    <= {32'd0, w_x_mag};
                        r_acc   <= '0;
                        r_k     <= '0;
                        r_phase <= 1'b0;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    // six limb products, each registered and added in the following cycle
                    if (r_k != 3'd6) begin
                        r_prod <= w_prod;
                        r_sh   <= w_ai + {1'b0, w_bj};
                    end
                    if (r_k != 3'd0) begin
                        r_acc <= r_acc + (128'(r_prod) << {r_sh, 5'd0});
                    end
                    if (r_k == 3'd6) begin
                        r_k     <= '0;
                        r_state <= r_phase ? S_DIV : S_T;
                    end else begin
                        r_k <= r_k + 3'd1;
                    end
                end
                S_T: begin
                    // subtract the signed diag*x magnitude held in the accumulator
                    if (r_diag[47] ^ r_x[31]) begin
                        r_t <= r_t + {2'b0, r_acc[79:0]};
                    end else begin
                        r_t <= r_t - {2'b0, r_acc[79:0]};
                    end
                    r_state <= S_T2;
                end
                S_T2: begin
                    r_negc  <= r_t[81] ^ r_diag[47];
                    r_ma    <= {14'd0, w_tmag};
                    r_mb    <= r_mode ? {16'd0, w_diag_mag} : {47'd0, r_damping};
                    r_acc   <= '0;
                    r_k     <= '0;
                    r_phase <= 1'b1;
                    r_state <= S_MUL;
                end
                S_DIV: begin
                    r_state <= S_DIVW;
                end
                S_DIVW: begin
                    if (w_div_done) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    r_res.out_row   <= r_in.row;
                    r_res.new_value <= w_fin_val;
                    r_res.status    <= (w_fin_sat || r_sat) ? ST_SAT : ST_OK;
                    r_diag  <= '0;
                    r_off   <= '0;
                    r_sq    <= '0;
                    r_sat   <= 1'b0;
                    r_state <= S_PUB;
                end
                S_PUB: begin
                    // hand the result to the output register once it is free
                    if (!r_ovalid || o_out.ready) begin
                        r_odata  <= r_res;
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign o_out.valid = r_ovalid;
    assign o_out.data  = r_odata;

    `SRRS_ASSERT_NEXT(a_pub_holds, i_clk, i_rst_n, (r_state == S_PUB && r_ovalid && !o_out.ready), (r_state == S_PUB))
    `SRRS_ASSERT_IMP(a_div_done_when_waiting, i_clk, i_rst_n, w_div_done, (r_state == S_DIVW))
    `SRRS_ASSERT_IMP(a_mem_write_states, i_clk, i_rst_n, w_we, (r_state == S_DEC || r_state == S_FIN))

endmodule
